// ===== rtl/core/fsqrt_pkg.sv =====
// Package for the single-precision square root pipeline.
// Holds field widths, stage count and shared stage types; no dependencies.
package fsqrt_pkg;
    localparam int unsigned NumStages  = 6;
    localparam int unsigned BitsPerStg = 4;  // result bits per stage
    localparam logic [31:0] QnanIndef  = 32'hFFC00000;
    localparam logic [31:0] QuietBit   = 32'h00400000;

    typedef struct packed {
        logic        special;  // result already known
        logic [31:0] spec_val;
        logic [7:0]  exp_out;
        logic [49:0] rem;      // partial remainder
        logic [23:0] root;     // partial root
        logic [47:0] rad;      // radicand bits not yet consumed
    } t_stage;
endpackage

// ===== rtl/core/fsqrt_front.sv =====
// Operand decode: special cases, subnormal normalization, exponent parity.
// Depends on fsqrt_pkg.
module fsqrt_front import fsqrt_pkg::*; (
    input  logic [31:0] i_x,
    output t_stage      o_st
);
    logic        sign;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [4:0]  lz;
    logic [23:0] m;
    logic [8:0]  ue;
    logic [24:0] m2;
    logic [8:0]  ue2;

    always_comb begin
        sign = i_x[31];
        bexp = i_x[30:23];
        frac = i_x[22:0];
        lz   = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) lz = 5'(22 - i);
        end
        if (bexp == 8'd0) begin
            m  = {1'b0, frac} << (lz + 5'd1);
            ue = 9'(23 - 32'(lz));
        end else begin
            m  = {1'b1, frac};
            ue = {1'b0, bexp} + 9'd23;
        end
        if (ue[0]) begin
            m2  = {m, 1'b0};
            ue2 = ue - 9'd1;
        end else begin
            m2  = {1'b0, m};
            ue2 = ue;
        end
        o_st.special  = 1'b1;
        o_st.spec_val = i_x;
        if (bexp == 8'hFF && frac != 23'd0) o_st.spec_val = i_x | QuietBit;
        else if (i_x[30:0] == 31'd0)          o_st.spec_val = i_x;
        else if (sign)                        o_st.spec_val = QnanIndef;
        else if (bexp == 8'hFF)               o_st.spec_val = i_x;
        else                                  o_st.special  = 1'b0;
        o_st.exp_out = 8'((ue2 >> 1) + 9'd52);
        o_st.rem     = '0;
        o_st.root    = '0;
        o_st.rad     = {m2[24:0], 23'd0};
    end
endmodule

// ===== rtl/core/fsqrt_stage.sv =====
// One pipeline step of restoring digit recurrence: four root bits.
// Depends on fsqrt_pkg.
module fsqrt_stage import fsqrt_pkg::*; (
    input  t_stage i_st,
    output t_stage o_st
);
    logic [49:0] r;
    logic [49:0] t;
    logic [23:0] q;
    logic [47:0] a;

    always_comb begin
        r = i_st.rem;
        q = i_st.root;
        a = i_st.rad;
        for (int k = 0; k < BitsPerStg; k++) begin
            r = {r[47:0], a[47:46]};
            a = {a[45:0], 2'b00};
            t = {24'd0, q, 2'b01};
            if (r >= t) begin
                r = r - t;
                q = {q[22:0], 1'b1};
            end else begin
                q = {q[22:0], 1'b0};
            end
        end
        o_st      = i_st;
        o_st.rem  = r;
        o_st.root = q;
        o_st.rad  = a;
    end
endmodule

// ===== rtl/core/float32_square_root_top.sv =====
// Single-precision square root, round to nearest even, x86 NaN rules.
// Pipeline: decode stage, six four-bit recurrence stages, round into the
// output register.
// Throughput: one word per cycle; the whole pipe advances when the output is free.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module float32_square_root_top import fsqrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_root_bits
);
    t_stage             r_st [NumStages+1];
    logic               r_v  [NumStages+1];
    t_stage             n_st [NumStages+1];
    logic [31:0]        r_out;
    logic               r_out_v;
    logic               adv;
    logic               up;
    t_stage             last;

    assign adv     = !r_out_v || i_ready;
    assign o_ready = adv;
    assign o_valid = r_out_v;
    assign o_root_bits = r_out;

    fsqrt_front u_front (.i_x(i_operand_bits), .o_st(n_st[0]));
    for (genvar g = 0; g < NumStages; g++) begin : g_stg
        fsqrt_stage u_stg (.i_st(r_st[g]), .o_st(n_st[g+1]));
    end

    assign last = r_st[NumStages];
    assign up   = last.rem > {26'd0, last.root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NumStages; i++) r_v[i] <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= NumStages; i++) r_v[i] <= r_v[i-1];
            r_out_v <= r_v[NumStages];
        end
        if (adv) begin
            for (int i = 0; i <= NumStages; i++) r_st[i] <= n_st[i];
            r_out <= last.special ? last.spec_val :
                     ({1'b0, last.exp_out, 23'd0} + {9'd0, last.root[22:0]} + {31'd0, up});
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_root_bits))
        else $error("output word changed while stalled");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v[NumStages] |=> o_valid)
        else $error("last stage word lost");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stall without pending output");
endmodule

// ===== dv/float32_square_root_top_tb.sv =====
// Testbench for float32_square_root_top: single-precision square root with x86 NaN rules.
// Depends on fsqrt_pkg and the RTL only; expected roots come from a local predictor.
module float32_square_root_top_tb;
    import fsqrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PipeLatency = 7;
    localparam int unsigned IdleLimit   = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_operand_bits;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_root_bits;

    logic [31:0] root_queue[$];
    int unsigned fail_count;
    int unsigned word_count;
    int unsigned root_count;
    int unsigned idle_cycles;
    logic        rx_stall_enable;

    float32_square_root_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operand_bits (i_operand_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_root_bits    (o_root_bits)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Correctly rounded root by an exact bitwise integer square root.
    function automatic logic [31:0] predict_root(logic [31:0] x);
        logic [7:0]  bexp;
        logic [22:0] frac;
        logic [31:0] m;
        int          ue;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] bitpos;
        logic [31:0] up;
        bexp = x[30:23];
        frac = x[22:0];
        if (bexp == 8'hFF && frac != 0) return x | QuietBit;
        if (x[30:0] == 0) return x;
        if (x[31]) return QnanIndef;
        if (bexp == 8'hFF) return x;
        if (bexp == 0) begin
            m = {9'd0, frac};
            ue = 24;
            while (m[23] == 1'b0) begin
                m = m << 1;
                ue--;
            end
        end else begin
            m = {8'd0, 1'b1, frac};
            ue = bexp + 23;
        end
        if (ue % 2 == 1) begin
            m = m << 1;
            ue--;
        end
        num = {32'd0, m} << 23;
        res = 0;
        bitpos = 64'd1 << 46;
        while (bitpos != 0) begin
            if (num >= res + bitpos) begin
                num = num - (res + bitpos);
                res = (res >> 1) + bitpos;
            end else begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        up = (num > res) ? 32'd1 : 32'd0;
        return (32'(ue / 2 + 52) << 23) + {9'd0, res[22:0]} + up;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one word; the expected root is queued when the handshake completes.
    // Valid stays high after the accept so that a word with no gap follows at once.
    task automatic send_operand(logic [31:0] value, bit use_gaps);
        int unsigned gap;
        gap = use_gaps ? gap_length() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operand_bits <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        root_queue.push_back(predict_root(value));
        word_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (root_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_values();
        send_operand(32'h00000000, 0);
        send_operand(32'h80000000, 0);
        send_operand(32'h7F800000, 0);
        send_operand(32'hFF800000, 0);
        send_operand(32'h7F800001, 0);  // signaling NaN, smallest payload
        send_operand(32'h7FBFFFFF, 0);  // signaling NaN, largest payload
        send_operand(32'h7FC00000, 0);
        send_operand(32'hFFFFFFFF, 0);  // negative quiet NaN passes through
        send_operand(32'hFF800001, 0);
        send_operand(32'hBF800000, 0);
        send_operand(32'h80000001, 0);
    endtask

    task automatic test_finite_edges();
        send_operand(32'h00000001, 0);  // smallest subnormal
        send_operand(32'h007FFFFF, 0);  // largest subnormal
        send_operand(32'h00400000, 0);
        send_operand(32'h00800000, 0);
        send_operand(32'h7F7FFFFF, 0);
        send_operand(32'h3F800000, 0);
        send_operand(32'h40000000, 0);
        send_operand(32'h40800000, 0);
        send_operand(32'h3F7FFFFF, 0);
        send_operand(32'h407FFFFF, 0);
        send_operand(32'h55555555, 0);
        send_operand(32'h2AAAAAAA, 0);
    endtask

    task automatic test_random_operands(int unsigned count);
        logic [31:0] value;
        int unsigned kind;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            value = $urandom();
            case (kind)
                0: value[30:23] = 8'h00;
                1: value[30:23] = 8'hFF;
                2, 3, 4, 5: value[31] = 1'b0;
                default: ;
            endcase
            send_operand(value, 1);
        end
    endtask

    // Back-to-back words against random output stalls, a full drain, then words with random gaps.
    task automatic test_streaming_and_drain();
        repeat (60) send_operand($urandom() & 32'h7FFFFFFF, 0);
        wait_drained();
        repeat (40) send_operand($urandom(), 1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!rx_stall_enable) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : (($urandom_range(0, 9) == 0) ?
                       1'b0 : i_ready);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            root_count++;
            if (root_queue.size() == 0) begin
                $display("%0t: unexpected root word, expected none, actual %h",
                         $time, o_root_bits);
                fail_count++;
            end else begin
                if (o_root_bits !== root_queue[0]) begin
                    $display("%0t: root_bits mismatch, expected %h, actual %h",
                             $time, root_queue[0], o_root_bits);
                    fail_count++;
                end
                void'(root_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operand_bits = '0;
        i_ready = 1'b0;
        fail_count = 0;
        word_count = 0;
        root_count = 0;
        idle_cycles = 0;
        rx_stall_enable = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_values();
        test_finite_edges();
        rx_stall_enable <= 1'b1;
        test_random_operands(400);
        test_streaming_and_drain();
        wait_drained();
        repeat (PipeLatency * 4) @(posedge i_clk);
        if (root_queue.size() != 0) fail_count++;
        $display("Sent %0d operands (zeros, infinities, NaNs, negatives, subnormals, random)",
                 word_count);
        $display("and checked %0d roots under random gaps and output stalls.", root_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
